@@ sv/ttrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ttrc_pkg
// Widths and constants shared by the three-term recurrence checksum files.
// ----------------------------------------------------------------------------
package ttrc_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned TERM_W  = 16;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned COEF_W  = 8;
  localparam int unsigned FACT_W  = DATA_W + 1;
  localparam int unsigned PROD_W  = FACT_W + TERM_W;
  localparam int unsigned SUB_W   = COEF_W + TERM_W;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned FOLD_W  = TERM_W + 1;

  localparam logic [POS_W-1:0]  ALPHA_MUL    = 8'd17;
  localparam logic [POS_W-1:0]  BETA_MUL     = 8'd31;
  localparam logic [TERM_W-1:0] FIRST_OFFSET = 16'd7;
  localparam logic [TERM_W-1:0] TERM_MOD     = 16'hFFFF;
  localparam logic [TERM_W-1:0] TERM_INIT    = 16'd1;

  // Multiple of the modulus that keeps the difference non-negative.
  localparam logic [SUM_W-1:0]  TERM_BIAS    = SUM_W'(65535 * 256);

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [TERM_W-1:0] term_t;
  typedef logic [POS_W-1:0]  pos_t;

endpackage

@@ sv/ttrc_in_if.sv @@
// ----------------------------------------------------------------------------
// ttrc_in_if
// Byte channel into the checksum: one message byte and its last flag per beat.
// ----------------------------------------------------------------------------
interface ttrc_in_if
  import ttrc_pkg::*;
();
  logic  valid;
  logic  ready;
  data_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ sv/ttrc_out_if.sv @@
// ----------------------------------------------------------------------------
// ttrc_out_if
// Result channel of the checksum: one checksum per beat.
// ----------------------------------------------------------------------------
interface ttrc_out_if
  import ttrc_pkg::*;
();
  logic  valid;
  logic  ready;
  term_t checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

@@ sv/three_term_recurrence_checksum.sv @@
// ----------------------------------------------------------------------------
// three_term_recurrence_checksum
// Byte stream checksum built on a three-term recurrence modulo 65535.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one message byte per beat with last_byte marking the final
//   byte. The first byte of a message seeds the current term with byte+7; each
//   later byte advances the recurrence using position-dependent coefficients.
//   out_ch gives one checksum beat per message, taken from the beat that
//   carried last_byte; bytes not marked last produce no beat.
//   The checksum is registered and valid on out_ch in the cycle after the last
//   byte is taken. Throughput: one byte per cycle while out_ch is not stalled,
//   set by the single term update (two multiplies of the terms and a fold
//   modulo 65535) between the state registers.
//   Reset (rst_n low, synchronous) drops any message in progress and empties
//   the output register. When the receiver stalls, the output register holds
//   its checksum and in_ch.ready stays low until the beat is taken.
// ----------------------------------------------------------------------------
module three_term_recurrence_checksum
  import ttrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ttrc_in_if.sink    in_ch,
  ttrc_out_if.source out_ch
);

  term_t previous_term_r, previous_term_nxt;
  term_t current_term_r,  current_term_nxt;
  pos_t  position_low_r,  position_low_nxt;
  logic  in_message_r,    in_message_nxt;
  logic  out_valid_r,     out_valid_nxt;
  term_t checksum_r,      checksum_nxt;

  logic               in_fire;
  pos_t               alpha;
  pos_t               beta;
  logic [FACT_W-1:0]  factor;
  logic [PROD_W-1:0]  prod;
  logic [SUB_W-1:0]   sub;
  logic               neg;
  logic [SUM_W-1:0]   diff;
  logic [FOLD_W-1:0]  fold;
  term_t              next_term;

  assign in_ch.ready     = !out_valid_r || out_ch.ready;
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.checksum = checksum_r;

  always_comb begin
    alpha     = POS_W'(position_low_r * ALPHA_MUL);
    beta      = POS_W'(position_low_r * BETA_MUL);
    factor    = FACT_W'(in_ch.data_byte) + FACT_W'(alpha);
    prod      = PROD_W'(factor) * PROD_W'(current_term_r);
    sub       = SUB_W'(beta) * SUB_W'(previous_term_r);
    neg       = PROD_W'(sub) > prod;
    diff      = SUM_W'(prod) + TERM_BIAS - SUM_W'(sub) + SUM_W'(neg);
    fold      = FOLD_W'(diff[TERM_W-1:0]) + FOLD_W'(diff[SUM_W-1:TERM_W]);
    if (fold >= FOLD_W'(TERM_MOD)) begin
      next_term = TERM_W'(fold - FOLD_W'(TERM_MOD));
    end else begin
      next_term = fold[TERM_W-1:0];
    end
  end

  always_comb begin
    previous_term_nxt = previous_term_r;
    current_term_nxt  = current_term_r;
    position_low_nxt  = position_low_r;
    in_message_nxt    = in_message_r;
    out_valid_nxt     = out_valid_r && !out_ch.ready;
    checksum_nxt      = checksum_r;
    if (in_fire) begin
      if (!in_message_r) begin
        previous_term_nxt = TERM_INIT;
        current_term_nxt  = TERM_W'(in_ch.data_byte) + FIRST_OFFSET;
        position_low_nxt  = POS_W'(1);
        in_message_nxt    = 1'b1;
      end else begin
        previous_term_nxt = current_term_r;
        current_term_nxt  = next_term;
        position_low_nxt  = position_low_r + POS_W'(1);
      end
      if (in_ch.last_byte) begin
        checksum_nxt      = current_term_nxt;
        out_valid_nxt     = 1'b1;
        previous_term_nxt = TERM_INIT;
        current_term_nxt  = TERM_INIT;
        position_low_nxt  = '0;
        in_message_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      previous_term_r <= TERM_INIT;
      current_term_r  <= TERM_INIT;
      position_low_r  <= '0;
      in_message_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      previous_term_r <= previous_term_nxt;
      current_term_r  <= current_term_nxt;
      position_low_r  <= position_low_nxt;
      in_message_r    <= in_message_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    checksum_r <= checksum_nxt;
  end

  a_last_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.last_byte |=> out_valid_r && !in_message_r)
    else $error("last byte did not produce a checksum beat");

  a_mid_stays_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_ch.last_byte |=> in_message_r)
    else $error("message closed without a last byte");

  a_term_shift: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_message_r && !in_ch.last_byte |=> previous_term_r == $past(current_term_r))
    else $error("previous term not advanced from current term");

  a_checksum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> checksum_r != TERM_MOD)
    else $error("checksum out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(checksum_r))
    else $error("pending checksum lost");

endmodule

@@ dv/tb_three_term_recurrence_checksum.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_term_recurrence_checksum
// Self-checking bench for the three-term recurrence checksum. Byte beats come
// from a queue that is filled phase by phase: a directed set of short
// messages, then random messages with random gaps, a stretch with no gaps, a
// long result-side hold-off and sender pauses until the block has drained.
// A local model of the recurrence predicts each checksum; every result beat
// is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_three_term_recurrence_checksum
  import ttrc_pkg::*;
();

  typedef longint unsigned u64_t;

  typedef struct {
    data_t data_byte;
    logic  last_byte;
    bit    drain_first;
  } byte_beat_t;

  localparam u64_t  ALPHA_STEP     = 64'd17;
  localparam u64_t  BETA_STEP      = 64'd31;
  localparam u64_t  COEF_MODULUS   = 64'd256;
  localparam u64_t  TERM_MODULUS   = 64'd65535;
  localparam term_t FIRST_BIAS     = 16'd7;
  localparam term_t TERM_SEED      = 16'd1;
  localparam int    IDLE_PCT       = 34;
  localparam int    HOLDOFF_CYCLES = 400;
  localparam int    CYCLE_LIMIT    = 200000;
  localparam int    PRINT_LIMIT    = 40;
  localparam int    DIR_N          = 21;

  // {last, byte}
  localparam logic [8:0] DIR_SEQ [DIR_N] = '{
    {1'b1, 8'd0},
    {1'b1, 8'd255},
    {1'b0, 8'd0},   {1'b1, 8'd0},
    {1'b0, 8'd255}, {1'b1, 8'd255},
    {1'b0, 8'd255}, {1'b0, 8'd0}, {1'b0, 8'd255}, {1'b0, 8'd0}, {1'b1, 8'd255},
    {1'b0, 8'd1},   {1'b0, 8'd2}, {1'b0, 8'd4},   {1'b0, 8'd8},
    {1'b0, 8'd16},  {1'b0, 8'd32}, {1'b0, 8'd64}, {1'b1, 8'd128},
    {1'b0, 8'd128}, {1'b1, 8'd127}
  };

  logic clk;
  logic rst_n;

  ttrc_in_if  in_bus ();
  ttrc_out_if out_bus ();

  three_term_recurrence_checksum i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  byte_beat_t pending_bytes [$];
  term_t      checksum_q [$];

  term_t prev_term   = TERM_SEED;
  term_t cur_term    = TERM_SEED;
  pos_t  next_pos    = '0;
  bit    mid_message = 1'b0;

  int src_idle_pct   = IDLE_PCT;
  int sink_idle_pct  = IDLE_PCT;
  int holdoff_reqs   = 0;
  int holdoff_served = 0;
  int lasts_sent     = 0;
  int sums_seen      = 0;
  int fault_count    = 0;
  int cycle_count    = 0;
  int items_queued   = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_fault(input string what);
    fault_count++;
    if (fault_count <= PRINT_LIMIT) $display("ERROR %0t: %s", $time, what);
  endtask

  task automatic fold_byte(input data_t b, input logic last);
    u64_t alpha;
    u64_t beta;
    u64_t prod;
    u64_t diff;
    if (!mid_message) begin
      prev_term   = TERM_SEED;
      cur_term    = term_t'(b) + FIRST_BIAS;
      next_pos    = pos_t'(1);
      mid_message = 1'b1;
    end else begin
      alpha     = (u64_t'(next_pos) * ALPHA_STEP) % COEF_MODULUS;
      beta      = (u64_t'(next_pos) * BETA_STEP) % COEF_MODULUS;
      prod      = (u64_t'(b) + alpha) * u64_t'(cur_term);
      // wraps modulo 2^64 on a negative difference
      diff      = prod - beta * u64_t'(prev_term);
      prev_term = cur_term;
      cur_term  = term_t'(diff % TERM_MODULUS);
      next_pos  = next_pos + pos_t'(1);
    end
    if (last) begin
      checksum_q.push_back(cur_term);
      prev_term   = TERM_SEED;
      cur_term    = TERM_SEED;
      next_pos    = '0;
      mid_message = 1'b0;
    end
  endtask

  task automatic queue_byte(input data_t b, input logic last, input bit drain_first);
    byte_beat_t beat;
    beat.data_byte   = b;
    beat.last_byte   = last;
    beat.drain_first = drain_first;
    pending_bytes.push_back(beat);
    items_queued++;
  endtask

  task automatic queue_message(input int len, input bit drain_first);
    data_t b;
    int    pick;
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(9);
      if (pick == 0) b = 8'h00;
      else if (pick == 1) b = 8'hFF;
      else b = data_t'($urandom_range(255));
      queue_byte(b, logic'(k == len - 1), drain_first && (k == 0));
    end
  endtask

  task automatic fill_phase(input int budget, input int drain_pct);
    int stop_at;
    int len;
    stop_at = items_queued + budget;
    while (items_queued < stop_at) begin
      if ($urandom_range(199) == 0) len = $urandom_range(300, 256);
      else if ($urandom_range(99) < 22) len = 1;
      else len = $urandom_range(12, 2);
      queue_message(len, $urandom_range(99) < drain_pct);
    end
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || checksum_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.data_byte   = '0;
    in_bus.last_byte   = 1'b0;
    out_bus.ready      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < DIR_N; k++) queue_byte(DIR_SEQ[k][7:0], DIR_SEQ[k][8], 1'b0);
    wait_idle();

    // cross the position wrap at least once
    queue_message(260, 1'b0);
    fill_phase(480, 0);
    wait_idle();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    fill_phase(300, 0);
    wait_idle();

    sink_idle_pct = IDLE_PCT;
    fill_phase(200, 0);
    holdoff_reqs++;
    wait_idle();

    src_idle_pct = IDLE_PCT;
    fill_phase(300, 12);
    wait_idle();

    repeat (4) @(negedge clk);
    if (checksum_q.size() != 0)
      report_fault($sformatf("%0d checksums never arrived", checksum_q.size()));
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin : drive_bytes
    bit offer;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        if (in_bus.last_byte) lasts_sent++;
        void'(pending_bytes.pop_front());
      end
      if (!(in_bus.valid && !in_bus.ready)) begin
        offer = 1'b0;
        if (pending_bytes.size() != 0) begin
          if (pending_bytes[0].drain_first && lasts_sent != sums_seen) offer = 1'b0;
          else offer = (src_idle_pct == 0) || ($urandom_range(99) >= src_idle_pct);
        end
        in_bus.valid <= offer;
        if (offer) begin
          in_bus.data_byte <= pending_bytes[0].data_byte;
          in_bus.last_byte <= pending_bytes[0].last_byte;
        end
      end
    end
  end

  always @(posedge clk) begin : drive_ready
    int hold_left;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (holdoff_served != holdoff_reqs) begin
        holdoff_served = holdoff_reqs;
        hold_left      = HOLDOFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_sums
    term_t want;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) fold_byte(in_bus.data_byte, in_bus.last_byte);
      if (out_bus.valid && out_bus.ready) begin
        sums_seen++;
        if (checksum_q.size() == 0) begin
          report_fault($sformatf("unexpected checksum beat %h", out_bus.checksum));
        end else begin
          want = checksum_q.pop_front();
          if (out_bus.checksum !== want)
            report_fault($sformatf("checksum %h, want %h", out_bus.checksum, want));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
